// File: src/snapshot_image_validator_assert.svh
// Assertion macros shared by the snapshot image validator RTL.
`ifndef SNAPSHOT_IMAGE_VALIDATOR_ASSERT_SVH
`define SNAPSHOT_IMAGE_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SIV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("snapshot image validator: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SIV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("snapshot image validator: assertion failed");

`endif

// File: src/siv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package siv_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_MSG     = 3'd1,
      ST_BAD_MAGIC   = 3'd2,
      ST_BAD_VERSION = 3'd3,
      ST_TOO_MANY    = 3'd4
   } status_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_EXPECTED_MAGIC = 2'd0,
      CSR_MIN_VERSION    = 2'd1,
      CSR_MAX_VERSION    = 2'd2,
      CSR_MAX_ENTRIES    = 2'd3
   } csr_index_type;

   localparam int          HEADER_BYTES  = 16;
   localparam logic [15:0] CNT_MAX       = 16'hFFFF;
   localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
   localparam logic [31:0] VERSION_ONE   = 32'd1;

endpackage

`default_nettype wire

// File: src/siv_crc_byte.sv
`timescale 1ns / 1ps
`default_nettype none

// Reflected CRC-32, one byte per evaluation.
module siv_crc_byte
   import siv_pkg::*;
(
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);

   always_comb begin
      logic [31:0] acc;
      acc = crc_cur ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
      crc_next = acc;
   end

endmodule

`default_nettype wire

// File: src/snapshot_image_validator.sv
// Snapshot image validator. Feed the stored image one byte per word on the
// req_ channel with req_tlast on the final byte; exactly one result word leaves
// on the rsp_ channel for every image, in the cycle after its last byte is taken.
// The first 16 bytes are the little-endian header (magic, version, entry count,
// payload CRC); checks run in that order, then the image must hold
// count * ENTRY_BYTES payload bytes, whose reflected CRC-32 must match the
// stored one. Bytes past the payload are ignored. Throughput is one byte per
// clock, set by the combinational byte-wide CRC update in siv_crc_byte; a
// result that sits unread in the output register holds off further bytes.
// Write the csr_ registers only while no image is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "snapshot_image_validator_assert.svh"

module snapshot_image_validator
   import siv_pkg::*;
#(
   parameter int ENTRY_LIMIT = 64,
   parameter int ENTRY_BYTES = 568
) (
   input  logic        clock,
   input  logic        reset,
   // Image bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [2:0] status, [9:3] entries,
                                    // [41:10] computed_crc, [47:42] zero
   // Configuration writes
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Payload length and total image length; keep at least 17 bits so the
   // counter-range check is always representable.
   localparam int PAY_W  = $clog2(ENTRY_LIMIT * ENTRY_BYTES + HEADER_BYTES + 1);
   localparam int NEED_W = (PAY_W > 17) ? PAY_W : 17;

   // Configuration registers
   logic [31:0] magic_cfg_ff;
   logic [31:0] min_ver_ff;
   logic [31:0] max_ver_ff;
   logic [6:0]  max_ent_ff;

   // Per-image state
   logic [15:0]      byte_cnt_ff, byte_cnt_in;
   logic [31:0]      magic_ff, magic_in;
   logic [31:0]      version_ff, version_in;
   logic [31:0]      count_ff, count_in;
   logic [31:0]      stored_ff, stored_in;
   logic [31:0]      crc_ff, crc_in;
   status_type       verdict_ff, verdict_in;
   logic [PAY_W-1:0] payload_ff, payload_in;

   // Result register
   logic        rsp_valid_ff;
   status_type  rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_count_ff, rsp_count_in;
   logic [31:0] rsp_crc_ff, rsp_crc_in;

   logic              accept;
   logic              hdr_phase;
   logic              hdr_done;
   logic [6:0]        limit;
   status_type        judge_verdict;
   logic [PAY_W-1:0]  judge_payload;
   status_type        verdict_now;
   logic [PAY_W-1:0]  payload_now;
   logic              crc_en;
   logic [31:0]       crc_upd;
   logic [31:0]       crc_fin;
   logic [NEED_W-1:0] need;
   logic [NEED_W-1:0] pay_pos;

   // A waiting result holds off the input side until it is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_crc_ff, rsp_count_ff, rsp_status_ff};

   siv_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (req_tdata),
      .crc_next  (crc_upd)
   );

   always_comb begin
      hdr_phase = (byte_cnt_ff < 16'(HEADER_BYTES));
      hdr_done  = (byte_cnt_ff == 16'(HEADER_BYTES - 1));

      // Drop header bytes into their word lanes
      magic_in   = magic_ff;
      version_in = version_ff;
      count_in   = count_ff;
      stored_in  = stored_ff;
      if (hdr_phase) begin
         case (byte_cnt_ff[3:2])
            2'd0:    magic_in[8*byte_cnt_ff[1:0] +: 8]   = req_tdata;
            2'd1:    version_in[8*byte_cnt_ff[1:0] +: 8] = req_tdata;
            2'd2:    count_in[8*byte_cnt_ff[1:0] +: 8]   = req_tdata;
            default: stored_in[8*byte_cnt_ff[1:0] +: 8]  = req_tdata;
         endcase
      end

      // Header verdict; magic, version and count are complete by now
      limit = (max_ent_ff > 7'(ENTRY_LIMIT)) ? 7'(ENTRY_LIMIT) : max_ent_ff;
      judge_payload = '0;
      if (magic_ff != magic_cfg_ff) begin
         judge_verdict = ST_BAD_MAGIC;
      end else if (version_ff < min_ver_ff || version_ff > max_ver_ff ||
                   version_ff != VERSION_ONE) begin
         judge_verdict = ST_BAD_VERSION;
      end else if (count_ff > {25'd0, limit}) begin
         judge_verdict = ST_TOO_MANY;
      end else begin
         judge_verdict = ST_OK;
         judge_payload = PAY_W'(count_ff[6:0]) * PAY_W'(ENTRY_BYTES);
      end

      verdict_now = hdr_done ? judge_verdict : verdict_ff;
      payload_now = hdr_done ? judge_payload : payload_ff;
      verdict_in  = verdict_now;
      payload_in  = payload_now;

      // Advance CRC only over the declared payload bytes
      pay_pos = NEED_W'(byte_cnt_ff - 16'(HEADER_BYTES));
      crc_en  = !hdr_phase && (verdict_ff == ST_OK) && (byte_cnt_ff != CNT_MAX) &&
                (pay_pos < NEED_W'(payload_ff));
      crc_in  = crc_en ? crc_upd : crc_ff;

      byte_cnt_in = (byte_cnt_ff == CNT_MAX) ? byte_cnt_ff : byte_cnt_ff + 16'd1;

      // Verdict for an image that ends on this byte
      need          = NEED_W'(HEADER_BYTES) + NEED_W'(payload_now);
      crc_fin       = ~crc_in;
      rsp_count_in  = '0;
      rsp_crc_in    = '0;
      if (byte_cnt_in < 16'(HEADER_BYTES)) begin
         rsp_status_in = ST_BAD_MSG;
      end else if (verdict_now != ST_OK) begin
         rsp_status_in = verdict_now;
      end else if (need > NEED_W'(CNT_MAX) || NEED_W'(byte_cnt_in) < need) begin
         rsp_status_in = ST_BAD_MSG;
      end else begin
         rsp_crc_in = crc_fin;
         if (crc_fin == stored_in) begin
            rsp_status_in = ST_OK;
            rsp_count_in  = count_in[6:0];
         end else begin
            rsp_status_in = ST_BAD_MSG;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_cfg_ff <= '0;
         min_ver_ff   <= 32'd1;
         max_ver_ff   <= 32'd1;
         max_ent_ff   <= 7'd64;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_EXPECTED_MAGIC: magic_cfg_ff <= csr_wdata;
            CSR_MIN_VERSION:    min_ver_ff   <= csr_wdata;
            CSR_MAX_VERSION:    max_ver_ff   <= csr_wdata;
            CSR_MAX_ENTRIES:    max_ent_ff   <= csr_wdata[6:0];
            default:            ;
         endcase
      end
   end

   // Image state: advance per byte, clear after the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         magic_ff    <= '0;
         version_ff  <= '0;
         count_ff    <= '0;
         stored_ff   <= '0;
         crc_ff      <= CRC_INIT;
         verdict_ff  <= ST_OK;
         payload_ff  <= '0;
      end else if (accept) begin
         if (req_tlast) begin
            byte_cnt_ff <= '0;
            magic_ff    <= '0;
            version_ff  <= '0;
            count_ff    <= '0;
            stored_ff   <= '0;
            crc_ff      <= CRC_INIT;
            verdict_ff  <= ST_OK;
            payload_ff  <= '0;
         end else begin
            byte_cnt_ff <= byte_cnt_in;
            magic_ff    <= magic_in;
            version_ff  <= version_in;
            count_ff    <= count_in;
            stored_ff   <= stored_in;
            crc_ff      <= crc_in;
            verdict_ff  <= verdict_in;
            payload_ff  <= payload_in;
         end
      end
   end

   // Result register: load on the last byte, hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_crc_ff    <= rsp_crc_in;
      end
   end

   `SIV_ASSERT_NEXT(a_frame_clear, clock, reset, accept && req_tlast,
                    byte_cnt_ff == 16'd0 && crc_ff == CRC_INIT)
   `SIV_ASSERT_NOW(a_reject_no_payload, clock, reset, verdict_ff != ST_OK,
                   payload_ff == '0)
   `SIV_ASSERT_NOW(a_header_fail_blank, clock, reset,
                   rsp_valid_ff && rsp_status_ff != ST_OK && rsp_status_ff != ST_BAD_MSG,
                   rsp_crc_ff == 32'd0 && rsp_count_ff == 7'd0)
   `SIV_ASSERT_NOW(a_ok_count_limit, clock, reset,
                   rsp_valid_ff && rsp_status_ff == ST_OK,
                   rsp_count_ff <= 7'(ENTRY_LIMIT) && rsp_count_ff <= max_ent_ff)

endmodule

`default_nettype wire

// File: tb/sv/snapshot_image_validator_tb.sv
`timescale 1ns / 1ps

module snapshot_image_validator_tb;
   import siv_pkg::*;

   localparam int ENTRY_LIMIT     = 64;
   localparam int ENTRY_BYTES     = 568;
   localparam int LONG_HOLD       = 400;   // receiver hold-off that backs up the input
   localparam int SETTLE_CYCLES   = 4;     // result leaves in the cycle after the last byte
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_CYCLES = 5000;  // well above the long hold-off

   // How the stored CRC word of a generated image is filled in
   typedef enum int {
      CRC_RAW,      // take the given word as it is
      CRC_SEALED,   // CRC of the payload bytes
      CRC_BROKEN    // CRC of the payload bytes with one bit flipped
   } crc_fill_type;

   // One result word as the block should report it
   typedef struct packed {
      status_type  status;
      logic [6:0]  entries;
      logic [31:0] crc;
   } verdict_type;

   // Byte-level model of the validator plus the queue of verdicts it owes
   class image_checker #(int LIMIT = 64, int BYTES_PER_ENTRY = 568);
      logic [31:0] magic_r;
      logic [31:0] min_ver_r;
      logic [31:0] max_ver_r;
      logic [6:0]  max_entries_r;

      logic [15:0] byte_count;
      logic [31:0] magic_w;
      logic [31:0] version_w;
      logic [31:0] count_w;
      logic [31:0] stored_w;
      logic [31:0] crc_acc;
      status_type  header_status;
      int unsigned payload_len;

      verdict_type expected_verdicts[$];
      int          errors;

      function void reset_all();
         magic_r       = '0;
         min_ver_r     = VERSION_ONE;
         max_ver_r     = VERSION_ONE;
         max_entries_r = 7'd64;
         errors        = 0;
         expected_verdicts.delete();
         clear_image();
      endfunction

      function void clear_image();
         byte_count    = '0;
         magic_w       = '0;
         version_w     = '0;
         count_w       = '0;
         stored_w      = '0;
         crc_acc       = CRC_INIT;
         header_status = ST_OK;
         payload_len   = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_EXPECTED_MAGIC: magic_r = value;
            CSR_MIN_VERSION:    min_ver_r = value;
            CSR_MAX_VERSION:    max_ver_r = value;
            CSR_MAX_ENTRIES:    max_entries_r = value[6:0];
            default: ;
         endcase
      endfunction

      // Reflected CRC-32, one byte, LSB first
      function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
         logic [31:0] r;
         r = acc ^ {24'h0, b};
         repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
         return r;
      endfunction

      function void judge_header();
         int unsigned limit;
         limit = max_entries_r;
         if (limit > LIMIT) limit = LIMIT;
         if (magic_w != magic_r) begin
            header_status = ST_BAD_MAGIC;
         end else if (version_w < min_ver_r || version_w > max_ver_r ||
                      version_w != VERSION_ONE) begin
            header_status = ST_BAD_VERSION;
         end else if (count_w > limit) begin
            header_status = ST_TOO_MANY;
         end else begin
            header_status = ST_OK;
            payload_len   = count_w * BYTES_PER_ENTRY;
         end
      endfunction

      // Note one accepted image byte; queue a verdict on the last one
      function void predict_byte(logic [7:0] b, logic last);
         logic [15:0] idx;
         int unsigned need;
         verdict_type v;
         idx = byte_count;
         if (idx < HEADER_BYTES) begin
            case (idx[3:2])
               2'd0: magic_w[idx[1:0] * 8 +: 8] = b;
               2'd1: version_w[idx[1:0] * 8 +: 8] = b;
               2'd2: count_w[idx[1:0] * 8 +: 8] = b;
               default: stored_w[idx[1:0] * 8 +: 8] = b;
            endcase
         end else if (header_status == ST_OK && idx < CNT_MAX &&
                      (idx - HEADER_BYTES) < payload_len) begin
            crc_acc = crc_step(crc_acc, b);
         end
         if (idx < CNT_MAX) byte_count = idx + 16'd1;
         if (idx == HEADER_BYTES - 1) judge_header();
         if (!last) return;

         need      = HEADER_BYTES + payload_len;
         v.status  = ST_BAD_MSG;
         v.entries = '0;
         v.crc     = '0;
         if (byte_count < HEADER_BYTES) begin
            v.status = ST_BAD_MSG;
         end else if (header_status != ST_OK) begin
            v.status = header_status;
         end else if (need > CNT_MAX || byte_count < need) begin
            v.status = ST_BAD_MSG;
         end else begin
            v.crc = ~crc_acc;
            if (v.crc == stored_w) begin
               v.status  = ST_OK;
               v.entries = count_w[6:0];
            end else begin
               v.status = ST_BAD_MSG;
            end
         end
         expected_verdicts.push_back(v);
         clear_image();
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // Compare one accepted result word with the oldest verdict
      function void check_verdict(logic [47:0] word);
         verdict_type v;
         if (expected_verdicts.size() == 0) begin
            $display("[%0t] unexpected result: expected none, actual %h", $time, word);
            errors++;
            return;
         end
         v = expected_verdicts.pop_front();
         check_field("status", 32'(v.status), 32'(word[2:0]));
         check_field("entries", 32'(v.entries), 32'(word[9:3]));
         check_field("computed_crc", v.crc, word[41:10]);
         check_field("pad", 32'd0, 32'(word[47:42]));
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   // Clock, reset and DUT ports; every input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] data_byte
   logic        req_tlast = 1'b0;  // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [2:0] status, [9:3] entries,
                                   // [41:10] computed_crc, [47:42] zero
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   image_checker #(ENTRY_LIMIT, ENTRY_BYTES) board;

   logic [7:0]  image_q[$];        // image under construction
   logic [31:0] cfg_magic = '0;    // mirror of the settings, for stimulus shaping
   int          cfg_limit = ENTRY_LIMIT;
   int          bytes_sent = 0;
   int          images_sent = 0;
   bit          req_quiet = 1'b0;
   bit          long_hold_req = 1'b0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   snapshot_image_validator #(
      .ENTRY_LIMIT (ENTRY_LIMIT),
      .ENTRY_BYTES (ENTRY_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Mostly no gap, sometimes a short one, rarely a long one
   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 75) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Entry count for a well-formed image: mostly empty, a few small ones
   function automatic int pick_count();
      int r;
      int c;
      r = $urandom_range(0, 99);
      c = (r < 90) ? 0 : (r < 98) ? 1 : 2;
      if (c > cfg_limit) c = cfg_limit;
      return c;
   endfunction

   // Offer one word and hold it until the block takes it
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.predict_byte(b, last);
      bytes_sent++;
   endtask

   // Send the first len bytes of the built image, last flag on the final one
   task automatic send_image(input int len);
      req_quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) send_byte(image_q[k], k == len - 1);
      images_sent++;
   endtask

   // Build header plus body_len random payload bytes
   task automatic make_image(input logic [31:0] magic, input logic [31:0] version,
                             input logic [31:0] count, input int body_len,
                             input crc_fill_type fill, input logic [31:0] crc_word);
      int          covered;
      int          flip;
      logic [31:0] acc;
      logic [31:0] stored;
      stored = crc_word;
      image_q.delete();
      repeat (HEADER_BYTES) image_q.push_back(8'h00);
      repeat (body_len) image_q.push_back(8'($urandom_range(0, 255)));
      if (fill != CRC_RAW) begin
         covered = (count <= ENTRY_LIMIT) ? count * ENTRY_BYTES : body_len;
         if (covered > body_len) covered = body_len;
         acc = CRC_INIT;
         for (int k = 0; k < covered; k++) acc = board.crc_step(acc, image_q[HEADER_BYTES + k]);
         stored = ~acc;
         if (fill == CRC_BROKEN) begin
            flip = $urandom_range(0, 31);
            stored[flip] = ~stored[flip];
         end
      end
      for (int k = 0; k < 4; k++) begin
         image_q[k]      = magic[8 * k +: 8];
         image_q[4 + k]  = version[8 * k +: 8];
         image_q[8 + k]  = count[8 * k +: 8];
         image_q[12 + k] = stored[8 * k +: 8];
      end
   endtask

   // Drop valid, wait out every owed result plus the block's latency
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.set_register(idx, value);
   endtask

   // Reprogram every register with the block idle
   task automatic apply_setting(input logic [31:0] magic, input logic [31:0] min_ver,
                                input logic [31:0] max_ver, input logic [6:0] max_ent);
      settle();
      write_csr(CSR_EXPECTED_MAGIC, magic);
      write_csr(CSR_MIN_VERSION, min_ver);
      write_csr(CSR_MAX_VERSION, max_ver);
      write_csr(CSR_MAX_ENTRIES, {25'd0, max_ent});
      csr_wr_en <= 1'b0;
      cfg_magic = magic;
      cfg_limit = (max_ent > ENTRY_LIMIT) ? ENTRY_LIMIT : max_ent;
   endtask

   // One random image: about half well-formed, the rest short or broken
   task automatic random_image();
      int           pick;
      int           body;
      logic [31:0]  cnt;
      logic [31:0]  ver;
      logic [31:0]  magic;
      crc_fill_type fill;
      pick  = $urandom_range(0, 99);
      magic = cfg_magic;
      ver   = VERSION_ONE;
      cnt   = pick_count();
      body  = $urandom_range(0, 4);
      fill  = CRC_RAW;
      if (pick < 10) begin
         // too short to hold a header
         make_image(magic, ver, cnt, 0, CRC_RAW, $urandom);
         send_image($urandom_range(1, HEADER_BYTES - 1));
         return;
      end
      if (pick < 20) begin
         magic = ($urandom_range(0, 1) != 0) ? magic ^ (32'h1 << $urandom_range(0, 31))
                                            : magic ^ ($urandom | 32'h1);
      end else if (pick < 30) begin
         case ($urandom_range(0, 3))
            0: ver = '0;
            1: ver = 32'd2;
            2: ver = '1;
            default: ver = $urandom | 32'h2;
         endcase
      end else if (pick < 40) begin
         cnt = ($urandom_range(0, 1) != 0) ? cfg_limit + 1 + $urandom_range(0, 3)
                                          : ($urandom | 32'h8000_0000);
      end else if (pick < 50 && cfg_limit > 0) begin
         // payload cut short: mostly far short, sometimes by a single byte
         cnt  = ($urandom_range(0, 3) == 0 && cfg_limit > 1) ? 2 : 1;
         body = ($urandom_range(0, 3) == 0) ? cnt * ENTRY_BYTES - 1
                                            : $urandom_range(0, 31);
         fill = CRC_SEALED;
      end else begin
         body = cnt * ENTRY_BYTES;
         if ($urandom_range(0, 3) == 0) body += $urandom_range(1, 8);
         fill = ($urandom_range(0, 4) == 0) ? CRC_BROKEN : CRC_SEALED;
      end
      make_image(magic, ver, cnt, body, fill, $urandom);
      send_image(image_q.size());
   endtask

   task automatic random_phase(input int byte_goal, input int verdict_goal);
      int bytes0;
      int images0;
      bytes0  = bytes_sent;
      images0 = images_sent;
      while (bytes_sent - bytes0 < byte_goal || images_sent - images0 < verdict_goal)
         random_image();
   endtask

   // Receiver: check each accepted word, then pick ready for the next cycle
   initial begin : rsp_side
      int  stall_left;
      bit  rsp_quiet;
      stall_left = 0;
      rsp_quiet  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_verdict(rsp_tdata);
         if ($urandom_range(0, 499) == 0) rsp_quiet = !rsp_quiet;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end else if (stall_left == 0) begin
            stall_left = pick_gap(rsp_quiet);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when neither side moves a word for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("snapshot_image_validator_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      board = new();
      board.reset_all();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: magic 0, version exactly 1, up to 64 entries
      make_image('0, VERSION_ONE, '0, 0, CRC_RAW, '0);
      send_image(1);                                   // one byte only
      send_image(HEADER_BYTES - 1);                    // one short of a header
      send_image(HEADER_BYTES);                        // empty payload, CRC of nothing
      make_image('0, VERSION_ONE, '0, 0, CRC_RAW, '1);
      send_image(HEADER_BYTES);                        // empty payload, wrong CRC
      make_image('1, VERSION_ONE, '0, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);                        // wrong magic
      make_image('0, '0, '0, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);                        // version zero
      make_image('0, 32'd2, '0, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);
      make_image('0, '1, '0, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);                        // version all ones
      make_image('0, VERSION_ONE, 32'd65, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);                        // one past the entry limit
      make_image('0, VERSION_ONE, '1, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);                        // count all ones
      make_image('0, VERSION_ONE, 32'd64, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);                        // count at the limit, no payload
      make_image('0, VERSION_ONE, 32'd1, ENTRY_BYTES + 7, CRC_SEALED, '0);
      send_image(image_q.size());                      // good entry, trailing bytes ignored
      make_image('0, VERSION_ONE, 32'd1, ENTRY_BYTES - 1, CRC_SEALED, '0);
      send_image(image_q.size());                      // payload one byte short

      // Any version in range, but only version 1 passes; no entries allowed
      apply_setting('1, '0, '1, 7'd0);
      make_image('1, VERSION_ONE, '0, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);
      make_image('1, VERSION_ONE, 32'd1, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);
      make_image('1, '0, '0, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);

      // Range that excludes version 1
      apply_setting($urandom, 32'd2, '1, 7'd1);
      make_image(cfg_magic, VERSION_ONE, '0, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);
      make_image(~cfg_magic, 32'd2, '0, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);
      apply_setting('0, '0, '0, 7'd64);
      make_image('0, '0, '0, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);
      make_image('0, VERSION_ONE, '0, 0, CRC_RAW, '0);
      send_image(HEADER_BYTES);

      // Hold the receiver off while short images keep coming: the unread
      // result backs up into the input and stalls it
      apply_setting('0, VERSION_ONE, VERSION_ONE, 7'd64);
      long_hold_req = 1'b1;
      repeat (12) begin
         make_image('0, VERSION_ONE, '0, 0, CRC_RAW, '0);
         send_image($urandom_range(1, HEADER_BYTES));
      end

      // Random images across several settings
      apply_setting($urandom, '0, '1, 7'd64);
      random_phase(100, 5);
      apply_setting('1, VERSION_ONE, VERSION_ONE, 7'd1);
      random_phase(100, 5);
      apply_setting('0, '0, VERSION_ONE, 7'($urandom_range(2, 63)));
      random_phase(100, 5);
      apply_setting($urandom, VERSION_ONE, 32'd7, 7'd0);
      random_phase(100, 5);

      // Drain what is still owed, then give the block time for strays
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("snapshot_image_validator_tb: PASS");
      end else begin
         $display("snapshot_image_validator_tb: FAIL");
      end
      $finish;
   end

endmodule
